// ===== design/slct_pkg.sv =====
// Shared types, codes and helpers for the segment limit and type checker.
package slct_pkg;

    localparam int NUM_SEGMENTS = 6;
    localparam int ADDR_W       = $clog2(NUM_SEGMENTS);

    // action codes
    localparam logic [1:0] ACT_CHECK = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_NEXT  = 2'd2;

    // segment codes
    localparam logic [2:0] SEG_CS   = 3'd0;
    localparam logic [2:0] SEG_SS   = 3'd1;
    localparam logic [2:0] SEG_NONE = 3'd7;

    // access kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // cpu modes
    localparam logic [1:0] MODE_REAL = 2'd0;
    localparam logic [1:0] MODE_PROT = 2'd1;
    localparam logic [1:0] MODE_V86  = 2'd2;

    localparam logic [31:0] REAL_OFF_MAX = 32'h0000_FFFF;
    localparam logic [31:0] EXPD_MAX_BYTE = 32'h0000_FFFF;
    localparam logic [31:0] EXPD_MAX_PAGE = 32'hFFFF_FFFF;
    localparam logic [11:0] PAGE_FILL     = 12'hFFF;

    // access byte bit positions
    localparam int ACC_S    = 4;
    localparam int ACC_EXEC = 3;
    localparam int ACC_EC   = 2;
    localparam int ACC_WR   = 1;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  segment;
        logic [15:0] selector;
        logic [31:0] offset;
        logic [1:0]  access_kind;
        logic [31:0] desc_base;
        logic [19:0] desc_limit;
        logic        desc_granular;
        logic [7:0]  desc_access;
    } t_item;

    typedef struct packed {
        logic        fault;
        logic [15:0] error_code;
        logic [31:0] segment_base;
    } t_result;

    typedef struct packed {
        logic [31:0] base;
        logic [19:0] limit;
        logic        granular;
        logic [7:0]  access;
    } t_desc;

    typedef struct packed {
        logic set_pending;
        logic clr_pending;
    } t_chk_ctl;

    function automatic logic seg_is_none(input logic [2:0] seg);
        return (seg == SEG_NONE) || ({29'd0, seg} >= 32'(NUM_SEGMENTS));
    endfunction

endpackage

// ===== design/slct_desc_ram.sv =====
// Descriptor cache: synchronous memory with per-entry valid bits.
module slct_desc_ram
    import slct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_desc             i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_desc             o_rd_data
);

    t_desc                   r_mem [NUM_SEGMENTS];
    logic [NUM_SEGMENTS-1:0] r_vld;
    t_desc                   r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits make a never-written entry read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== design/slct_check.sv =====
// Mode, type and limit checks on one word against its cached descriptor.
module slct_check
    import slct_pkg::*;
(
    input  t_item      i_item,
    input  t_desc      i_desc,
    input  logic [1:0] i_mode,
    input  logic       i_pending,
    output t_result    o_result,
    output t_chk_ctl   o_ctl
);

    logic        none;
    logic        realish;
    logic        s_bit, ex_bit, ec_bit, wr_bit;
    logic        is_read;
    logic        type_bad;
    logic        limit_bad;
    logic        prot_bad;
    logic [31:0] limit;
    logic [31:0] upper;
    logic [31:0] real_base;

    always_comb begin
        none      = seg_is_none(i_item.segment);
        realish   = (i_mode == MODE_REAL) || (i_mode == MODE_V86);
        s_bit     = i_desc.access[ACC_S];
        ex_bit    = i_desc.access[ACC_EXEC];
        ec_bit    = i_desc.access[ACC_EC];
        wr_bit    = i_desc.access[ACC_WR];
        is_read   = (i_item.access_kind == KIND_READ) || (i_item.access_kind == KIND_RSVD);
        real_base = {12'd0, i_item.selector, 4'd0};

        type_bad = 1'b0;
        // null selector on a data segment register
        if (i_item.segment != SEG_CS && i_item.segment != SEG_SS
                && i_item.selector[15:3] == 13'd0) begin
            type_bad = 1'b1;
        end
        if (i_item.segment == SEG_CS && i_item.access_kind == KIND_FETCH
                && !(ex_bit && s_bit)) begin
            type_bad = 1'b1;
        end
        if (i_item.access_kind == KIND_WRITE && s_bit && (ex_bit || !wr_bit)) begin
            type_bad = 1'b1;
        end
        if (is_read && s_bit && ex_bit && !wr_bit) begin
            type_bad = 1'b1;
        end

        limit = i_desc.granular ? {i_desc.limit, PAGE_FILL} : {12'd0, i_desc.limit};
        upper = i_desc.granular ? EXPD_MAX_PAGE : EXPD_MAX_BYTE;
        if (s_bit && !ex_bit && ec_bit) begin
            // expand-down data
            limit_bad = (i_item.offset <= limit) || (i_item.offset > upper);
        end else begin
            limit_bad = i_item.offset > limit;
        end
        prot_bad = type_bad || limit_bad;

        o_result = '0;
        o_ctl    = '0;
        case (i_item.action)
            ACT_CHECK: begin
                o_result.segment_base = (none || realish) ? real_base : i_desc.base;
                if (none) begin
                    o_result.fault = 1'b0;
                end else if (i_pending) begin
                    o_result.fault = 1'b1;
                end else if (realish) begin
                    o_result.fault = i_item.offset > REAL_OFF_MAX;
                end else if (prot_bad) begin
                    o_result.fault      = 1'b1;
                    o_result.error_code = i_item.selector;
                    o_ctl.set_pending   = 1'b1;
                end
            end
            ACT_NEXT: begin
                o_ctl.clr_pending = 1'b1;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== design/segment_limit_type_checker_unit.sv =====
// Segment limit and type checker, top level.
// An accepted word is checked in the check state; its result is registered, with o_valid, as the state returns to idle.
// No new word is accepted while busy; busy covers the check state, in which the descriptor memory read data is used.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset (sync, active low) clears mode, sticky fault, cache valid bits and control.
module segment_limit_type_checker_unit
    import slct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_item      i_item,
    output logic       o_valid,
    output t_result    o_result,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    logic       r_state, n_state;
    logic       r_pending, n_pending;
    logic [1:0] r_mode;
    logic       r_valid;
    t_item      r_item;
    t_result    r_result;

    logic       accept;
    logic       item_none;
    t_desc      wr_desc;
    t_desc      rd_desc;
    t_result    chk_result;
    t_chk_ctl   chk_ctl;

    assign busy      = (r_state == ST_CHECK);
    assign accept    = start && !busy;
    assign item_none = seg_is_none(i_item.segment);

    assign wr_desc.base     = i_item.desc_base;
    assign wr_desc.limit    = i_item.desc_limit;
    assign wr_desc.granular = i_item.desc_granular;
    assign wr_desc.access   = i_item.desc_access;

    // Loads write at the accept edge; the read for the next word cannot come
    // before the check state has passed, so no forwarding is needed.
    slct_desc_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && i_item.action == ACT_LOAD && !item_none),
        .i_wr_addr (i_item.segment[ADDR_W-1:0]),
        .i_wr_data (wr_desc),
        .i_rd_en   (accept && i_item.action == ACT_CHECK && !item_none),
        .i_rd_addr (i_item.segment[ADDR_W-1:0]),
        .o_rd_data (rd_desc)
    );

    slct_check u_check (
        .i_item    (r_item),
        .i_desc    (rd_desc),
        .i_mode    (r_mode),
        .i_pending (r_pending),
        .o_result  (chk_result),
        .o_ctl     (chk_ctl)
    );

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_IDLE;
                if (chk_ctl.set_pending) begin
                    n_pending = 1'b1;
                end else if (chk_ctl.clr_pending) begin
                    n_pending = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= 1'b0;
            r_mode    <= MODE_REAL;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_valid   <= (r_state == ST_CHECK);
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == ST_CHECK) begin
            r_result <= chk_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
